// File: src/alds_pkg.sv
// Shared types and constants for the averaged level display with slew limiting.
// Used by alds_window, alds_slew and the top level averaged_level_display_slew.
package alds_pkg;

   localparam int SMP_W   = 10;
   localparam int LVL_W   = 10;
   localparam int CNT_W   = 8;
   localparam int RAW_W   = 12;
   localparam int STEP_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam int SAMPLE_MAX = 1023;

   // Display scaling: target = (average * 3500) >> 10.
   localparam int GAIN_W = 12;
   localparam logic [GAIN_W-1:0] GAIN = 12'd3500;
   localparam int GAIN_SHIFT = 10;

   // Slew rules.
   localparam logic [LVL_W-1:0]  BIG_GAP   = 10'd100;
   localparam logic [STEP_W-1:0] BIG_STEP  = 4'd12;
   localparam logic [CNT_W-1:0]  FAST_RATE = 8'd70;
   localparam logic [CNT_W-1:0]  SLOW_RATE = 8'd200;

   // gap / 10 for gap <= 100 as (gap * 205) >> 11.
   localparam int DIV10_W = 15;
   localparam logic [7:0] DIV10_MUL = 8'd205;
   localparam int DIV10_SHIFT = 11;

   // Request codes.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_LIMIT = 2'd1;
   localparam logic [CNT_W-1:0] AVG_INTERVAL_RST = 8'd100;
   localparam logic [LVL_W-1:0] DISPLAY_LIMIT_RST = 10'd532;

   typedef struct packed {
      logic             req_type;
      logic [SMP_W-1:0] sample;
   } alds_req_type;

   typedef struct packed {
      logic [LVL_W-1:0] shown_level;
      logic [SMP_W-1:0] window_average;
   } alds_rsp_type;

   // Window average as seen by the display side; load marks a fresh value.
   typedef struct packed {
      logic             load;
      logic [SMP_W-1:0] value;
   } alds_avg_type;

   // Display status back to the sequencer.
   typedef struct packed {
      logic [CNT_W-1:0] rate;
      logic             raw_ok;
   } alds_disp_type;

endpackage

// File: src/averaged_level_display_slew.sv
// A sample beat or a tick without a window update finishes once the result register is
// free; a new beat is taken every cycle while results are not stalled and no window
// update runs. A tick that updates the window occupies the execute stage for memory
// read-modify-write, reciprocal multiply for the average, display scaling multiply, then
// the slew step. Reset clears the control state; the window memory reads as zero through
// per-entry valid bits, so beats are taken right after reset with no clearing pass.
module averaged_level_display_slew import alds_pkg::*; #(
   parameter int WINDOW_DEPTH = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  alds_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output alds_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_WAIT = 3'b010,
      ST_MOVE = 3'b100
   } alds_state_type;

   alds_state_type   state_ff, state_in;
   logic             ex_vld_ff;
   alds_req_type     ex_item_ff;
   logic [SMP_W-1:0] held_ff;
   logic [CNT_W-1:0] avg_cnt_ff, disp_cnt_ff;
   logic [CNT_W-1:0] interval_ff;
   logic [LVL_W-1:0] limit_ff;
   logic             rsp_vld_ff;
   alds_rsp_type     rsp_ff;
   logic             is_tick, avg_fire, disp_fire, out_free;
   logic             win_start, finish, move_en;
   logic [LVL_W-1:0] next_level;
   alds_avg_type     avg;
   alds_disp_type    disp;

   alds_window #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .start  (win_start),
      .sample (held_ff),
      .avg    (avg)
   );

   alds_slew u_slew (
      .clock      (clock),
      .reset      (reset),
      .avg        (avg),
      .move_en    (move_en),
      .limit      (limit_ff),
      .next_level (next_level),
      .disp       (disp)
   );

   assign is_tick   = ex_item_ff.req_type == REQ_TICK;
   assign avg_fire  = avg_cnt_ff >= interval_ff;
   assign disp_fire = disp_cnt_ff >= disp.rate;
   assign out_free  = !rsp_vld_ff || rsp_ready;

   always_comb begin
      win_start = 1'b0;
      finish    = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (ex_vld_ff) begin
               if (is_tick && avg_fire) begin
                  win_start = 1'b1;
                  state_in  = ST_WAIT;
               end else begin
                  finish = out_free;
               end
            end
         end
         ST_WAIT: begin
            if (disp.raw_ok) begin
               finish   = out_free;
               state_in = out_free ? ST_RUN : ST_MOVE;
            end
         end
         ST_MOVE: begin
            finish = out_free;
            if (out_free) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign move_en   = finish && is_tick && disp_fire;
   assign req_ready = !ex_vld_ff || finish;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ex_item_ff <= req_data;
      end
      if (finish) begin
         rsp_ff.shown_level    <= next_level;
         rsp_ff.window_average <= avg.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         ex_vld_ff   <= 1'b0;
         held_ff     <= '0;
         avg_cnt_ff  <= '0;
         disp_cnt_ff <= '0;
         interval_ff <= AVG_INTERVAL_RST;
         limit_ff    <= DISPLAY_LIMIT_RST;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_ready) begin
            ex_vld_ff <= req_valid;
         end
         if (finish && !is_tick) begin
            held_ff <= ex_item_ff.sample;
         end
         // A tick that finishes in the run state did not fire the window counter.
         if (win_start) begin
            avg_cnt_ff <= '0;
         end else if (finish && is_tick && state_ff == ST_RUN) begin
            avg_cnt_ff <= avg_cnt_ff + 1'b1;
         end
         if (finish && is_tick) begin
            disp_cnt_ff <= disp_fire ? '0 : disp_cnt_ff + 1'b1;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_AVG_INTERVAL) begin
               interval_ff <= csr_wdata[CNT_W-1:0];
            end else if (csr_index == CSR_DISPLAY_LIMIT) begin
               limit_ff <= csr_wdata[LVL_W-1:0];
            end
         end
         if (finish) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_busy_is_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> ex_vld_ff && is_tick)
      else $error("window update in progress without a pending tick");

   a_wait_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT && !disp.raw_ok |-> !req_ready && !finish)
      else $error("beat taken while the average was still being computed");

endmodule

// File: src/alds_window.sv
// Sample window memory with running sum and the divide-by-depth pipeline.
// Depends on alds_pkg.
module alds_window import alds_pkg::*; #(
   parameter int WINDOW_DEPTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SMP_W-1:0] sample,
   output alds_avg_type     avg
);

   localparam int SUM_W = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
   localparam int PROD_W = SUM_W + SHIFT;
   localparam int RECIP_INT = (2 ** SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
   localparam logic [SHIFT-1:0] RECIP = SHIFT'(RECIP_INT);
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_DEPTH * SAMPLE_MAX);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);

   logic [SMP_W-1:0]        mem [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic [PTR_W-1:0]        ptr_ff;
   logic [SMP_W-1:0]        rd_data_ff;
   logic                    rd_vld_ff;
   logic [SMP_W-1:0]        oldest;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic                    sum_go_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic                    prod_go_ff;
   logic [SMP_W-1:0]        avg_ff;
   logic                    avg_load_ff;

   // The read port always looks at the oldest entry, so it is ready well
   // before the next window update.
   always_ff @(posedge clock) begin
      if (start) begin
         mem[ptr_ff] <= sample;
      end
      rd_data_ff <= mem[ptr_ff];
      prod_ff    <= PROD_W'(sum_ff) * PROD_W'(RECIP);
   end

   // An entry never written stands for a zero sample.
   assign oldest = rd_vld_ff ? rd_data_ff : '0;
   assign sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ptr_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         sum_ff      <= '0;
         sum_go_ff   <= 1'b0;
         prod_go_ff  <= 1'b0;
         avg_ff      <= '0;
         avg_load_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= valid_ff[ptr_ff];
         sum_go_ff   <= start;
         prod_go_ff  <= sum_go_ff;
         avg_load_ff <= prod_go_ff;
         if (start) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= (ptr_ff == LAST_PTR) ? '0 : ptr_ff + 1'b1;
            sum_ff           <= sum_in;
         end
         if (prod_go_ff) begin
            avg_ff <= prod_ff[SHIFT +: SMP_W];
         end
      end
   end

   assign avg.load  = avg_load_ff;
   assign avg.value = avg_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      start |-> !sum_go_ff && !prod_go_ff && !avg_load_ff)
      else $error("window update started while the average pipeline was busy");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_MAX)
      else $error("running window sum out of range");

endmodule

// File: src/alds_slew.sv
// Display target scaling and slew-limited level update.
// Depends on alds_pkg; the average comes from alds_window.
module alds_slew import alds_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  alds_avg_type     avg,
   input  logic             move_en,
   input  logic [LVL_W-1:0] limit,
   output logic [LVL_W-1:0] next_level,
   output alds_disp_type    disp
);

   localparam int PROD_W = SMP_W + GAIN_W;

   logic [PROD_W-1:0]  scaled;
   logic [RAW_W-1:0]   raw_ff;
   logic               raw_ok_ff;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [CNT_W-1:0]   rate_ff, rate_in;
   logic [LVL_W-1:0]   target;
   logic               move_dn, move_up, big;
   logic [LVL_W-1:0]   gap;
   logic [DIV10_W-1:0] tenth;
   logic [STEP_W-1:0]  step, drop;

   assign scaled = PROD_W'(avg.value) * PROD_W'(GAIN);

   // The clamp stays outside the register so a new limit takes effect at once.
   assign target  = (raw_ff > RAW_W'(limit)) ? limit : raw_ff[LVL_W-1:0];
   assign move_dn = level_ff > target;
   assign move_up = level_ff < target;
   assign gap     = move_dn ? level_ff - target : target - level_ff;
   assign big     = gap > BIG_GAP;
   assign tenth   = DIV10_W'(gap[6:0]) * DIV10_W'(DIV10_MUL);
   assign step    = big ? BIG_STEP : tenth[DIV10_SHIFT +: STEP_W] + 1'b1;
   assign drop    = {1'b0, step[STEP_W-1:1]} + 1'b1;

   always_comb begin
      level_in = level_ff;
      rate_in  = rate_ff;
      if (move_en && (move_dn || move_up)) begin
         rate_in = big ? FAST_RATE : SLOW_RATE;
         if (move_dn) begin
            level_in = level_ff - LVL_W'(drop);
         end else begin
            level_in = level_ff + LVL_W'(step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= '0;
         raw_ok_ff <= 1'b0;
         level_ff  <= '0;
         rate_ff   <= '0;
      end else begin
         raw_ok_ff <= avg.load;
         if (avg.load) begin
            raw_ff <= scaled[GAIN_SHIFT +: RAW_W];
         end
         level_ff <= level_in;
         rate_ff  <= rate_in;
      end
   end

   assign next_level  = level_in;
   assign disp.rate   = rate_ff;
   assign disp.raw_ok = raw_ok_ff;

   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      !move_en |=> $stable(level_ff) && $stable(rate_ff))
      else $error("display level or rate changed without a display step");

endmodule

// File: sim/averaged_level_display_slew_tb.sv
// Testbench for averaged_level_display_slew: drives sample and tick beats and register
// writes, predicts the shown level and window average of every beat, checks results in order.
// Depends on alds_pkg and the averaged_level_display_slew top level.
module averaged_level_display_slew_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import alds_pkg::*;

   localparam int WINDOW_DEPTH  = 12;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   alds_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   alds_rsp_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int mismatches    = 0;
   int band_lo       = 0;
   int band_hi       = SAMPLE_MAX;

   // Predicted state of the block and its register copies.
   logic [CNT_W-1:0] interval_cfg;
   logic [LVL_W-1:0] limit_cfg;
   logic [SMP_W-1:0] held_reading;
   logic [SMP_W-1:0] reading_window [WINDOW_DEPTH];
   logic [SMP_W-1:0] window_mean;
   logic [CNT_W-1:0] mean_ticks;
   logic [CNT_W-1:0] slew_ticks;
   logic [CNT_W-1:0] slew_period;
   logic [LVL_W-1:0] level_now;
   alds_rsp_type     expected_levels [$];

   averaged_level_display_slew #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // A long hold-off, once requested, is counted here and overrides the random stalls.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      alds_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result beat with nothing expected: level %0d average %0d",
                        rsp_data.shown_level, rsp_data.window_average);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_data.shown_level !== want.shown_level ||
                rsp_data.window_average !== want.window_average) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected level %0d average %0d, got level %0d average %0d",
                           want.shown_level, want.window_average,
                           rsp_data.shown_level, rsp_data.window_average);
            end
         end
      end
   end

   // Picks the slew step for a gap and the number of ticks until the next move.
   task automatic pick_stride(input int gap, output int stride);
      if (gap > int'(BIG_GAP)) begin
         slew_period = FAST_RATE;
         stride      = int'(BIG_STEP);
      end else begin
         slew_period = SLOW_RATE;
         stride      = gap / 10 + 1;
      end
   endtask

   task automatic predict_beat(input alds_req_type beat);
      int           total;
      int           target;
      int           stride;
      int           k;
      alds_rsp_type result;
      if (beat.req_type == REQ_SAMPLE) begin
         held_reading = beat.sample;
      end else begin
         // The window update, when due, comes before the display update of the same tick.
         if (mean_ticks >= interval_cfg) begin
            mean_ticks = '0;
            total = 0;
            for (k = 0; k < WINDOW_DEPTH - 1; k++) begin
               reading_window[k] = reading_window[k + 1];
               total += reading_window[k];
            end
            reading_window[WINDOW_DEPTH - 1] = held_reading;
            total += held_reading;
            window_mean = SMP_W'(total / WINDOW_DEPTH);
         end else begin
            mean_ticks = mean_ticks + 1'b1;
         end
         if (slew_ticks >= slew_period) begin
            slew_ticks = '0;
            target = (int'(window_mean) * int'(GAIN)) >> GAIN_SHIFT;
            if (target > int'(limit_cfg))
               target = int'(limit_cfg);
            // Moving down takes only half a step plus one.
            if (int'(level_now) > target) begin
               pick_stride(int'(level_now) - target, stride);
               level_now = LVL_W'(int'(level_now) - (stride / 2 + 1));
            end
            if (int'(level_now) < target) begin
               pick_stride(target - int'(level_now), stride);
               level_now = LVL_W'(int'(level_now) + stride);
            end
         end else begin
            slew_ticks = slew_ticks + 1'b1;
         end
      end
      result.shown_level    = level_now;
      result.window_average = window_mean;
      expected_levels.push_back(result);
   endtask

   task automatic send_beat(input alds_req_type beat);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      predict_beat(beat);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers in back-to-back beats; only called while the block is idle.
   task automatic apply_settings(input int interval, input int limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_AVG_INTERVAL;
      csr_wdata <= CSR_DATA_W'(interval);
      do @(posedge clock); while (!csr_ready);
      interval_cfg = CNT_W'(interval);
      csr_index <= CSR_DISPLAY_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      do @(posedge clock); while (!csr_ready);
      limit_cfg = LVL_W'(limit);
      csr_valid <= 1'b0;
   endtask

   // Mostly ticks; samples mostly stay in a band so the average settles and the level moves.
   function automatic alds_req_type random_beat();
      alds_req_type beat;
      int           pick;
      pick        = $urandom_range(99);
      beat.sample = SMP_W'($urandom_range(SAMPLE_MAX));
      if (pick < 65) begin
         beat.req_type = REQ_TICK;
      end else begin
         beat.req_type = REQ_SAMPLE;
         if (pick < 69)
            beat.sample = (pick & 1) ? SMP_W'(SAMPLE_MAX) : '0;
         else if (pick >= 76)
            beat.sample = SMP_W'($urandom_range(band_hi, band_lo));
      end
      return beat;
   endfunction

   task automatic test_directed_extremes();
      alds_req_type     beat;
      logic [SMP_W-1:0] corner [5] = '{10'h3FF, 10'h000, 10'h2AA, 10'h155, 10'h3FF};
      int               n;
      // Right after reset the target equals the level, so the first tick moves nothing.
      beat.req_type = REQ_TICK;
      beat.sample   = SMP_W'(SAMPLE_MAX);
      send_beat(beat);
      beat.req_type = REQ_SAMPLE;
      for (n = 0; n < 5; n++) begin
         beat.sample = corner[n];
         send_beat(beat);
      end
      settle();
      apply_settings(1, 1023);
      beat.req_type = REQ_TICK;
      for (n = 0; n < 12; n++) begin
         beat.sample = (n & 1) ? 10'h2AA : 10'h155;
         send_beat(beat);
      end
      settle();
      apply_settings(1, 0);
      beat.req_type = REQ_SAMPLE;
      beat.sample   = '0;
      send_beat(beat);
      beat.req_type = REQ_TICK;
      send_beat(beat);
      send_beat(beat);
   endtask

   task automatic test_interval_wrap();
      alds_req_type beat;
      settle();
      apply_settings(255, 700);
      beat.req_type = REQ_SAMPLE;
      beat.sample   = 10'd900;
      send_beat(beat);
      // With the widest interval the window takes a new entry only every 256th tick.
      beat.req_type = REQ_TICK;
      repeat (270) send_beat(beat);
      settle();
      // The counter now sits past the new interval and must fire on the next tick.
      apply_settings(3, 700);
      repeat (8) send_beat(beat);
   endtask

   task automatic test_random(input int beats, input int idle, input int stall,
                              input int interval, input int limit);
      int n;
      int center;
      settle();
      apply_settings(interval, limit);
      send_idle_pct = idle;
      stall_pct    <= stall;
      for (n = 0; n < beats; n++) begin
         if (n % 120 == 0) begin
            center  = $urandom_range(SAMPLE_MAX);
            band_lo = (center > 32) ? center - 32 : 0;
            band_hi = (center + 32 < SAMPLE_MAX) ? center + 32 : SAMPLE_MAX;
         end
         send_beat(random_beat());
      end
   endtask

   task automatic test_result_backpressure();
      settle();
      send_idle_pct = 0;
      stall_pct    <= 0;
      hold_requests <= hold_requests + 1;
      repeat (40) send_beat(random_beat());
   endtask

   initial begin
      interval_cfg = AVG_INTERVAL_RST;
      limit_cfg    = DISPLAY_LIMIT_RST;
      held_reading = '0;
      foreach (reading_window[k])
         reading_window[k] = '0;
      window_mean  = '0;
      mean_ticks   = '0;
      slew_ticks   = '0;
      slew_period  = '0;
      level_now    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_interval_wrap();
      test_random(260, 0, 0, 1, 1023);
      test_random(250, 77, 0, $urandom_range(3, 1), $urandom_range(1023, 300));
      test_result_backpressure();
      test_random(250, 0, 77, 2, $urandom_range(400, 0));
      test_random(250, 26, 26, $urandom_range(8, 1), $urandom_range(1023, 0));
      settle();

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
src/alds_pkg.sv
src/alds_window.sv
src/alds_slew.sv
src/averaged_level_display_slew.sv
sim/averaged_level_display_slew_tb.sv
